[design/ocdd_pkg.sv]
package ocdd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 17;
    localparam int DELTA_W   = 16;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 1'b1;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] RELEASE_RESET   = 16'd4800;

    localparam logic [DELTA_W-1:0] DELTA_SAT = 16'hFFFF;

    // Queue between the classifier and the detector.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // The divider produces one quotient bit per cycle.
    localparam int DIV_STEPS  = 16;
    localparam int DIV_STEP_W = 4;

    typedef struct packed {
        logic hit_a;
        logic hit_b;
    } hits_t;

endpackage

[design/ocdd_in_if.sv]
interface ocdd_in_if #(
    parameter int SAMPLE_WIDTH = ocdd_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_a;
    logic signed [SAMPLE_WIDTH-1:0] sample_b;

    modport source (output valid, output sample_a, output sample_b, input ready);
    modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

[design/ocdd_out_if.sv]
interface ocdd_out_if ();
    logic                            valid;
    logic                            ready;
    logic                            trigger;
    logic [ocdd_pkg::DELTA_W-1:0]    delta;
    logic [ocdd_pkg::COUNT_W-1:0]    hit_samples;

    modport source (output valid, output trigger, output delta, output hit_samples,
                    input ready);
    modport sink   (input valid, input trigger, input delta, input hit_samples,
                    output ready);
endinterface

[design/ocdd_cfg_if.sv]
interface ocdd_cfg_if ();
    logic                           valid;
    logic                           ready;
    logic [ocdd_pkg::CFG_IDX_W-1:0] index;
    logic [ocdd_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/ocdd_front.sv]
module ocdd_front #(
    parameter int SAMPLE_WIDTH = ocdd_pkg::SAMPLE_WIDTH_DEF
) (
    ocdd_in_if.sink                   samples,
    input  logic [ocdd_pkg::CFG_W-1:0] threshold,
    output logic                      push_valid,
    output ocdd_pkg::hits_t           push_data,
    input  logic                      push_ready
);

    localparam int MAG_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W = (MAG_W > ocdd_pkg::CFG_W) ? MAG_W : ocdd_pkg::CFG_W;

    logic [MAG_W-1:0] ext_a;
    logic [MAG_W-1:0] ext_b;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [CMP_W-1:0] thr_cmp;

    // One extra bit keeps the magnitude of the most negative sample exact.
    assign ext_a = {samples.sample_a[SAMPLE_WIDTH-1], samples.sample_a};
    assign ext_b = {samples.sample_b[SAMPLE_WIDTH-1], samples.sample_b};
    assign mag_a = ext_a[MAG_W-1] ? (~ext_a + 1'b1) : ext_a;
    assign mag_b = ext_b[MAG_W-1] ? (~ext_b + 1'b1) : ext_b;

    assign thr_cmp = CMP_W'(threshold);

    assign push_data.hit_a = CMP_W'(mag_a) >= thr_cmp;
    assign push_data.hit_b = CMP_W'(mag_b) >= thr_cmp;
    assign push_valid      = samples.valid;
    assign samples.ready   = push_ready;

endmodule

[design/ocdd_queue.sv]
module ocdd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  ocdd_pkg::hits_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output ocdd_pkg::hits_t pop_data,
    input  logic            pop_ready
);

    ocdd_pkg::hits_t                     entries_reg [ocdd_pkg::QUEUE_DEPTH];
    logic [ocdd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [ocdd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [ocdd_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [ocdd_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                                push;
    logic                                pop;

    assign push_ready = count_reg != ocdd_pkg::QUEUE_CNT_W'(ocdd_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/ocdd_back.sv]
module ocdd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    input  ocdd_pkg::hits_t            pop_data,
    output logic                       pop_ready,
    input  logic [ocdd_pkg::CFG_W-1:0] release_samples,
    ocdd_out_if.source                 results
);

    localparam logic [1:0] MODE_WAITING   = 2'd0;
    localparam logic [1:0] MODE_HIT_A     = 2'd1;
    localparam logic [1:0] MODE_HIT_B     = 2'd2;
    localparam logic [1:0] MODE_RELEASING = 2'd3;

    localparam logic SEQ_RUN = 1'b0;
    localparam logic SEQ_DIV = 1'b1;

    localparam int CW = ocdd_pkg::COUNT_W;
    localparam int DW = ocdd_pkg::DELTA_W;

    logic [1:0]                       mode_reg,  mode_next;
    logic                             seq_reg,   seq_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [DW-1:0]                    last_delta_reg, last_delta_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_trigger_reg, out_trigger_next;
    logic [DW-1:0]                    out_delta_reg, out_delta_next;
    logic [CW-1:0]                    out_hits_reg, out_hits_next;
    logic [DW-1:0]                    rem_reg, rem_next;
    logic [DW-1:0]                    lo_reg, lo_next;
    logic [DW-1:0]                    quo_reg, quo_next;
    logic [ocdd_pkg::DIV_STEP_W-1:0]  step_reg, step_next;

    logic          out_free;
    logic          take;
    logic [CW-1:0] inc;
    logic          expired;
    logic          hit;
    logic [CW-1:0] hit_cnt;
    logic          other;
    logic          sat;
    logic [CW-1:0] rel_ext;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic          ge;

    assign out_free  = !out_valid_reg || results.ready;
    assign pop_ready = (seq_reg == SEQ_RUN) && out_free;
    assign take      = pop_valid && pop_ready;
    assign inc       = count_reg + 1'b1;
    assign rel_ext   = CW'(release_samples);
    assign expired   = inc > rel_ext;

    // A quotient above the 16-bit range means count >= 2 * release_samples.
    assign sat = hit_cnt >= {release_samples, 1'b0};

    assign trial = {rem_reg, lo_reg[DW-1]};
    assign ge    = trial >= rel_ext;
    assign diff  = trial - rel_ext;

    always_comb
    begin
        mode_next        = mode_reg;
        seq_next         = seq_reg;
        count_next       = count_reg;
        last_delta_next  = last_delta_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_trigger_next = out_trigger_reg;
        out_delta_next   = out_delta_reg;
        out_hits_next    = out_hits_reg;
        rem_next         = rem_reg;
        lo_next          = lo_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        hit              = 1'b0;
        hit_cnt          = '0;
        other            = 1'b0;

        if (take)
        begin
            unique case (mode_reg)
                MODE_WAITING:
                begin
                    if (pop_data.hit_a && pop_data.hit_b)
                    begin
                        hit     = 1'b1;
                        hit_cnt = count_reg;
                    end
                    else if (pop_data.hit_a)
                    begin
                        mode_next = MODE_HIT_A;
                    end
                    else if (pop_data.hit_b)
                    begin
                        mode_next = MODE_HIT_B;
                    end
                end
                MODE_HIT_A, MODE_HIT_B:
                begin
                    other = (mode_reg == MODE_HIT_A) ? pop_data.hit_b : pop_data.hit_a;
                    if (other)
                    begin
                        hit     = 1'b1;
                        hit_cnt = inc;
                    end
                    else if (expired)
                    begin
                        mode_next  = MODE_WAITING;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = inc;
                    end
                end
                MODE_RELEASING:
                begin
                    if (expired)
                    begin
                        mode_next  = MODE_WAITING;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = inc;
                    end
                end
                default:
                begin
                    mode_next = MODE_WAITING;
                end
            endcase

            if (hit)
            begin
                mode_next        = MODE_RELEASING;
                count_next       = '0;
                out_trigger_next = 1'b1;
                out_hits_next    = hit_cnt;
                if (sat)
                begin
                    out_delta_next  = ocdd_pkg::DELTA_SAT;
                    last_delta_next = ocdd_pkg::DELTA_SAT;
                    out_valid_next  = 1'b1;
                end
                else
                begin
                    // Dividend is hit_cnt << 15; its top bits seed the remainder.
                    seq_next  = SEQ_DIV;
                    rem_next  = hit_cnt[CW-1:1];
                    lo_next   = {hit_cnt[0], {(DW-1){1'b0}}};
                    step_next = '0;
                end
            end
            else
            begin
                out_trigger_next = 1'b0;
                out_hits_next    = '0;
                out_delta_next   = last_delta_reg;
                out_valid_next   = 1'b1;
            end
        end
        else if (seq_reg == SEQ_DIV)
        begin
            rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next  = {quo_reg[DW-2:0], ge};
            lo_next   = {lo_reg[DW-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == ocdd_pkg::DIV_STEP_W'(ocdd_pkg::DIV_STEPS - 1))
            begin
                seq_next        = SEQ_RUN;
                out_delta_next  = {quo_reg[DW-2:0], ge};
                last_delta_next = {quo_reg[DW-2:0], ge};
                out_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_WAITING;
            seq_reg        <= SEQ_RUN;
            count_reg      <= '0;
            last_delta_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            seq_reg        <= seq_next;
            count_reg      <= count_next;
            last_delta_reg <= last_delta_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_trigger_reg <= out_trigger_next;
        out_delta_reg   <= out_delta_next;
        out_hits_reg    <= out_hits_next;
        rem_reg         <= rem_next;
        lo_reg          <= lo_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.trigger     = out_trigger_reg;
    assign results.delta       = out_delta_reg;
    assign results.hit_samples = out_hits_reg;

endmodule

[design/two_channel_onset_delta_detector.sv]
// Channel   Dir   Payload                                  Accepted when
// samples   in    sample_a, sample_b (signed)              valid && ready
// results   out   trigger, delta (Q1.15), hit_samples      valid && ready
// cfg       in    index (0 threshold, 1 release), data     valid && ready (always ready)
//
// An item that ends in no pair hit passes the detector into a registered result; the
// front is combinational and the two-entry queue registers the item, so such items
// stream one per cycle while the result output does not stall. A pair hit holds the detector
// while the one-bit-per-cycle divider forms delta; a hit whose delta saturates skips it.
// Reset clears the mode, the count, the held delta, the queue and the output valid.
// A stalled result output holds the detector; the queue keeps taking items until full.
module two_channel_onset_delta_detector #(
    parameter int SAMPLE_WIDTH = ocdd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ocdd_in_if.sink     samples,
    ocdd_out_if.source  results,
    ocdd_cfg_if.sink    cfg
);

    logic [ocdd_pkg::CFG_W-1:0] threshold_reg;
    logic [ocdd_pkg::CFG_W-1:0] release_reg;

    logic            push_valid;
    ocdd_pkg::hits_t push_data;
    logic            push_ready;
    logic            pop_valid;
    ocdd_pkg::hits_t pop_data;
    logic            pop_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ocdd_pkg::THRESHOLD_RESET;
            release_reg   <= ocdd_pkg::RELEASE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ocdd_pkg::REG_THRESHOLD: threshold_reg <= cfg.data;
                ocdd_pkg::REG_RELEASE:   release_reg   <= cfg.data;
                default:                 ;
            endcase
        end
    end

    ocdd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .samples    (samples),
        .threshold  (threshold_reg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    ocdd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    ocdd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_data        (pop_data),
        .pop_ready       (pop_ready),
        .release_samples (release_reg),
        .results         (results)
    );

endmodule

[sim/onset_pair_checker.sv]
`timescale 1ns / 100ps

module onset_pair_checker #(
    parameter int SW = ocdd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    ocdd_in_if    samples,
    ocdd_out_if   results,
    ocdd_cfg_if   cfg,
    output int    fail_count,
    output int    pending_results,
    output int    results_checked,
    output int    triggers_seen
);

    typedef enum logic [1:0] {
        ST_WAITING,
        ST_HIT_A,
        ST_HIT_B,
        ST_RELEASING
    } onset_mode_t;

    typedef struct packed {
        logic                         trigger;
        logic [ocdd_pkg::DELTA_W-1:0] delta;
        logic [ocdd_pkg::COUNT_W-1:0] hit_samples;
    } onset_result_t;

    onset_result_t expected_onsets[$];
    onset_result_t want;
    onset_result_t predicted;

    logic [ocdd_pkg::CFG_W-1:0]   thr_reg;
    logic [ocdd_pkg::CFG_W-1:0]   rel_reg;
    onset_mode_t                  mode_q;
    logic [ocdd_pkg::COUNT_W-1:0] count_q;
    logic [ocdd_pkg::DELTA_W-1:0] delta_held;

    function automatic logic [SW:0] magnitude_of(logic signed [SW-1:0] s);
        logic [SW:0] v;
        logic [SW:0] full;
        v = {1'b0, s};
        full = '0;
        full[SW] = 1'b1;
        // The most negative sample has a magnitude one past the positive range.
        return s[SW-1] ? (full - v) : v;
    endfunction

    function automatic logic [ocdd_pkg::DELTA_W-1:0] onset_delta(
        logic [ocdd_pkg::COUNT_W-1:0] n,
        logic [ocdd_pkg::CFG_W-1:0]   rel);
        logic [63:0] q;
        if (rel == '0)
            return ocdd_pkg::DELTA_SAT;
        q = (64'(n) << 15) / 64'(rel);
        return (q > 64'(ocdd_pkg::DELTA_SAT)) ? ocdd_pkg::DELTA_SAT
                                              : q[ocdd_pkg::DELTA_W-1:0];
    endfunction

    task automatic close_pair(inout onset_result_t r);
        delta_held = onset_delta(count_q, rel_reg);
        r.trigger = 1'b1;
        r.delta = delta_held;
        r.hit_samples = count_q;
        mode_q = ST_RELEASING;
        count_q = '0;
    endtask

    task automatic predict_onset(input logic signed [SW-1:0] a_s,
                                 input logic signed [SW-1:0] b_s,
                                 output onset_result_t r);
        ocdd_pkg::hits_t crossed;
        crossed.hit_a = magnitude_of(a_s) >= (SW+1)'(thr_reg);
        crossed.hit_b = magnitude_of(b_s) >= (SW+1)'(thr_reg);
        r.trigger = 1'b0;
        r.delta = delta_held;
        r.hit_samples = '0;
        case (mode_q)
            ST_WAITING:
            begin
                if (crossed.hit_a && crossed.hit_b)
                    close_pair(r);
                else if (crossed.hit_a)
                    mode_q = ST_HIT_A;
                else if (crossed.hit_b)
                    mode_q = ST_HIT_B;
            end
            ST_HIT_A, ST_HIT_B:
            begin
                // The count moves first, and a crossing wins over window expiry.
                count_q = count_q + 1'b1;
                if ((mode_q == ST_HIT_A) ? crossed.hit_b : crossed.hit_a)
                    close_pair(r);
                else if (count_q > ocdd_pkg::COUNT_W'(rel_reg))
                begin
                    mode_q = ST_WAITING;
                    count_q = '0;
                end
            end
            default:
            begin
                count_q = count_q + 1'b1;
                if (count_q > ocdd_pkg::COUNT_W'(rel_reg))
                begin
                    mode_q = ST_WAITING;
                    count_q = '0;
                end
            end
        endcase
    endtask

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_onsets.delete();
            thr_reg = ocdd_pkg::THRESHOLD_RESET;
            rel_reg = ocdd_pkg::RELEASE_RESET;
            mode_q = ST_WAITING;
            count_q = '0;
            delta_held = '0;
            fail_count = 0;
            pending_results = 0;
            results_checked = 0;
            triggers_seen = 0;
        end
        else
        begin
            // A result can never belong to the item accepted at the same edge,
            // so the comparison runs before the new prediction is queued.
            if (results.valid && results.ready)
            begin
                if (expected_onsets.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, trigger %0d delta %0d hit_samples %0d",
                             $time, results.trigger, results.delta, results.hit_samples);
                end
                else
                begin
                    want = expected_onsets.pop_front();
                    report_field("trigger", 32'(want.trigger), 32'(results.trigger));
                    report_field("delta", 32'(want.delta), 32'(results.delta));
                    report_field("hit_samples", 32'(want.hit_samples),
                                 32'(results.hit_samples));
                    results_checked++;
                    if (want.trigger)
                        triggers_seen++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    ocdd_pkg::REG_THRESHOLD: thr_reg = cfg.data;
                    ocdd_pkg::REG_RELEASE:   rel_reg = cfg.data;
                    default:                 ;
                endcase
            end
            if (samples.valid && samples.ready)
            begin
                predict_onset(samples.sample_a, samples.sample_b, predicted);
                expected_onsets.push_back(predicted);
            end
            pending_results = expected_onsets.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int SW          = ocdd_pkg::SAMPLE_WIDTH_DEF;
    localparam int FULL_SCALE  = 1 << (SW - 1);
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;

    ocdd_in_if  #(.SAMPLE_WIDTH(SW)) samples_ch ();
    ocdd_out_if                      results_ch ();
    ocdd_cfg_if                      cfg_ch ();

    int fail_count;
    int pending_results;
    int results_checked;
    int triggers_seen;

    int unsigned items_sent = 0;
    int unsigned settings_count = 0;
    int unsigned cur_thr = ocdd_pkg::THRESHOLD_RESET;
    int unsigned cur_rel = ocdd_pkg::RELEASE_RESET;
    int unsigned quiet_cycles = 0;
    bit sender_idle_on = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit hold_request = 1'b0;

    two_channel_onset_delta_detector #(.SAMPLE_WIDTH(SW)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    onset_pair_checker #(.SW(SW)) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (samples_ch),
        .results         (results_ch),
        .cfg             (cfg_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .triggers_seen   (triggers_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [SW-1:0] any_sample();
        return SW'($urandom);
    endfunction

    // Magnitude strictly below the current threshold.
    function automatic logic signed [SW-1:0] quiet_sample();
        logic signed [SW-1:0] v;
        if (cur_thr == 0)
            return any_sample();
        v = SW'($urandom_range(cur_thr - 1, 0));
        return ($urandom_range(1, 0) != 0) ? -v : v;
    endfunction

    // Magnitude at or above the current threshold.
    function automatic logic signed [SW-1:0] hot_sample();
        int unsigned m;
        logic signed [SW-1:0] v;
        m = $urandom_range(FULL_SCALE, cur_thr);
        if (m >= FULL_SCALE)
            return {1'b1, {(SW-1){1'b0}}};
        v = SW'(m);
        return ($urandom_range(1, 0) != 0) ? -v : v;
    endfunction

    task automatic send_pair(input logic signed [SW-1:0] a_s,
                             input logic signed [SW-1:0] b_s);
        while (sender_idle_on && $urandom_range(99, 0) < 33)
        begin
            samples_ch.valid <= 1'b0;
            @(negedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.sample_a <= a_s;
        samples_ch.sample_b <= b_s;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Registers change only once every queued result has drained.
    task automatic write_config(input int unsigned thr, input int unsigned rel);
        samples_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= ocdd_pkg::REG_THRESHOLD;
        cfg_ch.data <= ocdd_pkg::CFG_W'(thr);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.index <= ocdd_pkg::REG_RELEASE;
        cfg_ch.data <= ocdd_pkg::CFG_W'(rel);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_thr = thr;
        cur_rel = rel;
        settings_count++;
    endtask

    task automatic run_random_phase(input int unsigned thr, input int unsigned rel,
                                    input int unsigned n);
        int unsigned first_item;
        int unsigned span;
        int unsigned gap;
        int unsigned kind;
        write_config(thr, rel);
        first_item = items_sent;
        span = (rel > 40) ? 40 : rel;
        while (items_sent - first_item < n)
        begin
            if ($urandom_range(99, 0) < 20)
            begin
                repeat ($urandom_range(3, 1))
                    send_pair(any_sample(), any_sample());
            end
            else
            begin
                repeat ($urandom_range(2, 0))
                    send_pair(quiet_sample(), quiet_sample());
                kind = $urandom_range(2, 0);
                gap = $urandom_range(span + 2, 0);
                // A gap past the window lets the first onset expire unpaired.
                if (kind == 2)
                    send_pair(hot_sample(), hot_sample());
                else if (kind == 0)
                begin
                    send_pair(hot_sample(), quiet_sample());
                    repeat (gap)
                        send_pair(any_sample(), quiet_sample());
                    send_pair(any_sample(), hot_sample());
                end
                else
                begin
                    send_pair(quiet_sample(), hot_sample());
                    repeat (gap)
                        send_pair(quiet_sample(), any_sample());
                    send_pair(hot_sample(), any_sample());
                end
                repeat ($urandom_range(span + 1, 0))
                    send_pair(any_sample(), any_sample());
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            else
                results_ch.ready <= !(receiver_idle_on && $urandom_range(99, 0) < 33);
        end
    end

    always @(posedge clk)
    begin
        if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending_results);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.sample_a = '0;
        samples_ch.sample_b = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ocdd_pkg::REG_THRESHOLD;
        cfg_ch.data = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: threshold edge, A then B three samples apart.
        send_pair(16'sd16383, -16'sd16383);
        send_pair(16'sd16384, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd32767, 16'sd0);
        send_pair(16'sd0, -16'sd16384);

        // One-sample window: hold-off, simultaneous hit, saturated delta at
        // release plus one, and an onset that expires without a partner.
        write_config(16384, 1);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, -16'sd32768);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd32768, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd16384, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd16384);

        // Zero release is out of range: every hit saturates, no divide.
        write_config(16384, 0);
        send_pair(16'sd32767, 16'sd0);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd32768, 16'sd16384);
        send_pair(-16'sd1, 16'sd1);

        // Widest window with no idling at all: a long gap between the
        // onsets against the largest divisor.
        write_config(16384, 65535);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        send_pair(16'sd16384, 16'sd0);
        repeat (100)
            send_pair(any_sample(), quiet_sample());
        send_pair(16'sd0, -16'sd16384);
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;

        run_random_phase(16384, 6, 120);
        run_random_phase(0, 3, 80);
        run_random_phase(FULL_SCALE, 4, 100);
        run_random_phase(1, 1, 80);
        run_random_phase($urandom_range(FULL_SCALE - 1, 1), 0, 80);

        // The sender keeps offering while the result side is held off.
        samples_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        hold_request = 1'b1;
        sender_idle_on = 1'b0;
        run_random_phase($urandom_range(FULL_SCALE - 1, 1), $urandom_range(40, 2), 120);
        sender_idle_on = 1'b1;

        run_random_phase(500, 12, 120);
        run_random_phase(12000, 200, 80);
        run_random_phase($urandom_range(FULL_SCALE, 0), $urandom_range(16, 1), 80);

        samples_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (40)
            @(posedge clk);

        $display("Sent %0d sample pairs under %0d register settings, with a %0d-cycle",
                 items_sent, settings_count, HOLD_CYCLES);
        $display("output stall and a wide window; %0d results compared, %0d pair hits.",
                 results_checked, triggers_seen);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
